[src/mbte_pkg.sv]
`default_nettype none
package mbte_pkg;

	// configuration register indexes
	localparam int unsigned CfgIndexW = 1;
	localparam logic [CfgIndexW-1:0] CFG_STRIP_HEADERS = 1'd0;
	localparam logic [CfgIndexW-1:0] CFG_STRIP_HTML    = 1'd1;
	localparam int unsigned CfgDataW = 1;

	// header prefix and content type pattern
	localparam int unsigned PrefixLen  = 13;
	localparam int unsigned PatternLen = 9;
	localparam int unsigned PosW       = 4;

	localparam logic [7:0] PREFIX_TEXT [PrefixLen] = '{
		8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74,
		8'h2d, 8'h74, 8'h79, 8'h70, 8'h65, 8'h3a
	};
	localparam logic [7:0] PATTERN_TEXT [PatternLen] = '{
		8'h74, 8'h65, 8'h78, 8'h74, 8'h2f, 8'h68, 8'h74, 8'h6d, 8'h6c
	};
	// longest proper border of each pattern prefix
	localparam logic [PosW-1:0] PATTERN_FALL [PatternLen] = '{
		4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0
	};

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_LT = 8'h3c;
	localparam logic [7:0] CHAR_GT = 8'h3e;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       line_end;
		logic       message_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_line_end;
	} out_item_t;

endpackage
`default_nettype wire

[src/mail_body_text_extractor_top.sv]
`default_nettype none
// mail body text extractor
//
// in channel: one message byte per item, with a line_end mark on the last
// byte of each line and a message_start mark on the first byte of a message.
// out channel: at most one item per input item; a kept byte (byte_valid 1)
// and/or a line end mark. dropped bytes that do not end a line give nothing.
// header lines are dropped when strip_headers is set; in the body of a
// message whose header has a content-type line naming text/html, tags from
// '<' through '>' are dropped when strip_html is set.
//
// result: out_valid is registered and rises in the cycle after an emitting
// item is accepted. throughput: one item per cycle while no stall holds the
// result register; the whole per-byte update (prefix compare, pattern matcher
// step, tag flag) fits between the state registers and the result register.
// reset: all phase and match state cleared, both strip options set, output
// register empty.
// stall: while out_stall holds a waiting result, in_stall is raised and the
// result register holds; an item is taken in the same cycle the result drains.
// configuration is written through cfg_we / cfg_index / cfg_data while idle.
module mail_body_text_extractor_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire mbte_pkg::in_item_t               in_item,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output mbte_pkg::out_item_t                   out_item,
	input  wire logic                             cfg_we,
	input  wire logic [mbte_pkg::CfgIndexW-1:0]   cfg_index,
	input  wire logic [mbte_pkg::CfgDataW-1:0]    cfg_data
);

	localparam logic [mbte_pkg::PosW-1:0] PREFIX_END =
		mbte_pkg::PrefixLen[mbte_pkg::PosW-1:0];
	localparam logic [mbte_pkg::PosW-1:0] PATTERN_END =
		mbte_pkg::PatternLen[mbte_pkg::PosW-1:0];

	// one step of the text/html matcher, failure chain is at most two links
	function automatic logic [mbte_pkg::PosW-1:0] match_step(
		input logic [mbte_pkg::PosW-1:0] k_in,
		input logic [7:0]                lc
	);
		logic [mbte_pkg::PosW-1:0] k;
		logic                      hit;
		k   = k_in;
		hit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (!hit) begin
				if (lc == mbte_pkg::PATTERN_TEXT[k]) begin
					hit = 1'b1;
				end else if (k != '0) begin
					k = mbte_pkg::PATTERN_FALL[k - 4'd1];
				end
			end
		end
		return hit ? k + 4'd1 : '0;
	endfunction

	// configuration
	logic strip_headers_q;
	logic strip_html_q;

	// phase and match state
	logic                      in_body_q;
	logic                      html_body_q;
	logic                      in_tag_q;
	logic [mbte_pkg::PosW-1:0] line_pos_q;
	logic                      prefix_ok_q;
	logic [mbte_pkg::PosW-1:0] type_progress_q;
	logic                      html_seen_q;
	logic                      blank_line_q;

	// result register
	logic                out_valid_q;
	mbte_pkg::out_item_t out_item_q;

	logic accept;

	// state as seen by this byte (after a message start clears it)
	logic                      cur_in_body;
	logic                      cur_html_body;
	logic                      cur_in_tag;
	logic [mbte_pkg::PosW-1:0] cur_line_pos;
	logic                      cur_prefix_ok;
	logic [mbte_pkg::PosW-1:0] cur_progress;
	logic                      cur_html_seen;
	logic                      cur_blank;

	// updated state
	logic                      nxt_in_body;
	logic                      nxt_html_body;
	logic                      nxt_in_tag;
	logic [mbte_pkg::PosW-1:0] nxt_line_pos;
	logic                      nxt_prefix_ok;
	logic [mbte_pkg::PosW-1:0] nxt_progress;
	logic                      nxt_html_seen;
	logic                      nxt_blank;

	logic [7:0]                lc;
	logic [mbte_pkg::PosW-1:0] step_k;
	logic                      keep;
	logic                      emit;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign lc = (in_item.data_byte >= 8'h41 && in_item.data_byte <= 8'h5a)
		? in_item.data_byte + 8'd32 : in_item.data_byte;
	assign step_k = match_step(cur_progress, lc);

	always_comb begin
		// message start abandons everything before this byte
		if (in_item.message_start) begin
			cur_in_body   = 1'b0;
			cur_html_body = 1'b0;
			cur_in_tag    = 1'b0;
			cur_line_pos  = '0;
			cur_prefix_ok = 1'b1;
			cur_progress  = '0;
			cur_html_seen = 1'b0;
			cur_blank     = 1'b0;
		end else begin
			cur_in_body   = in_body_q;
			cur_html_body = html_body_q;
			cur_in_tag    = in_tag_q;
			cur_line_pos  = line_pos_q;
			cur_prefix_ok = prefix_ok_q;
			cur_progress  = type_progress_q;
			cur_html_seen = html_seen_q;
			cur_blank     = blank_line_q;
		end

		nxt_in_body   = cur_in_body;
		nxt_html_body = cur_html_body;
		nxt_in_tag    = cur_in_tag;
		nxt_line_pos  = cur_line_pos;
		nxt_prefix_ok = cur_prefix_ok;
		nxt_progress  = cur_progress;
		nxt_html_seen = cur_html_seen;
		nxt_blank     = cur_blank;
		keep          = 1'b1;

		if (!cur_in_body) begin
			// header line: run the prefix compare and the pattern matcher
			keep = !strip_headers_q;
			if (cur_line_pos == '0 && (in_item.data_byte == mbte_pkg::CHAR_CR
				|| in_item.data_byte == mbte_pkg::CHAR_LF)) begin
				nxt_blank = 1'b1;
			end
			if (cur_line_pos < PREFIX_END) begin
				if (lc != mbte_pkg::PREFIX_TEXT[cur_line_pos]) begin
					nxt_prefix_ok = 1'b0;
				end
				nxt_line_pos = cur_line_pos + 4'd1;
			end
			if (step_k == PATTERN_END) begin
				nxt_html_seen = 1'b1;
				nxt_progress  = '0;
			end else begin
				nxt_progress = step_k;
			end
			if (in_item.line_end) begin
				if (nxt_line_pos == PREFIX_END && nxt_prefix_ok && nxt_html_seen) begin
					nxt_html_body = 1'b1;
				end
				if (nxt_blank) begin
					nxt_in_body = 1'b1;
				end
			end
		end else if (strip_html_q && cur_html_body) begin
			// html body: drop tag bytes
			if (!cur_in_tag) begin
				if (in_item.data_byte == mbte_pkg::CHAR_LT) begin
					nxt_in_tag = 1'b1;
					keep       = 1'b0;
				end
			end else begin
				if (in_item.data_byte == mbte_pkg::CHAR_GT) begin
					nxt_in_tag = 1'b0;
				end
				keep = 1'b0;
			end
		end

		// line end starts a fresh line
		if (in_item.line_end) begin
			nxt_line_pos  = '0;
			nxt_prefix_ok = 1'b1;
			nxt_progress  = '0;
			nxt_html_seen = 1'b0;
			nxt_blank     = 1'b0;
			nxt_in_tag    = 1'b0;
		end

		emit = keep || in_item.line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_headers_q <= 1'b1;
			strip_html_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbte_pkg::CFG_STRIP_HEADERS: strip_headers_q <= cfg_data[0];
				mbte_pkg::CFG_STRIP_HTML:    strip_html_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q       <= 1'b0;
			html_body_q     <= 1'b0;
			in_tag_q        <= 1'b0;
			line_pos_q      <= '0;
			prefix_ok_q     <= 1'b1;
			type_progress_q <= '0;
			html_seen_q     <= 1'b0;
			blank_line_q    <= 1'b0;
		end else if (accept) begin
			in_body_q       <= nxt_in_body;
			html_body_q     <= nxt_html_body;
			in_tag_q        <= nxt_in_tag;
			line_pos_q      <= nxt_line_pos;
			prefix_ok_q     <= nxt_prefix_ok;
			type_progress_q <= nxt_progress;
			html_seen_q     <= nxt_html_seen;
			blank_line_q    <= nxt_blank;
		end
	end

	// output valid: filled by an item that emits, drained when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_item_q.out_byte     <= keep ? in_item.data_byte : 8'd0;
			out_item_q.byte_valid   <= keep;
			out_item_q.out_line_end <= in_item.line_end;
		end
	end

endmodule
`default_nettype wire

[dv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// longest legitimate quiet stretch is the receiver hold-off below
	localparam int HOLD_CYCLES    = 400;
	localparam int QUIET_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int CHUNK_BYTES    = 210;

	// header prefix and content type pattern, first character in the top byte
	localparam int                PREFIX_CHARS = 13;
	localparam int                TYPE_CHARS   = 9;
	localparam logic [8*13-1:0]   HDR_PREFIX   = "content-type:";
	localparam logic [8*9-1:0]    TYPE_PAT     = "text/html";
	// border of each pattern prefix is 0 or 1 here; bit j set means the prefix
	// of length j+1 has a border of one character ("text", "text/ht")
	localparam logic [0:8]        TYPE_BORDER1 = 9'b000100100;

	// how a generated line is closed
	typedef enum int {
		TERM_BARE,   // line_end on the last text byte, no newline byte
		TERM_LF,
		TERM_CRLF,
		TERM_CR,
		TERM_CUT     // no line_end at all, the line is abandoned
	} line_term_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	mbte_pkg::in_item_t             in_item = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	mbte_pkg::out_item_t            out_item;
	logic                           cfg_we = 1'b0;
	logic [mbte_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [mbte_pkg::CfgDataW-1:0]  cfg_data = '0;

	mail_body_text_extractor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// byte stream waiting to be offered, and kept text still to come out
	mbte_pkg::in_item_t  bytes_to_send [$];
	mbte_pkg::out_item_t kept_text_due [$];
	logic [7:0] line_buf [$];
	bit        msg_fresh = 1'b0;
	bit        in_taken = 1'b0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	bit        rx_hold = 1'b0;
	bit        pressure_go = 1'b0;
	int        mismatches = 0;
	int        quiet_cycles = 0;

	// extractor state as the block should hold it
	bit        cfg_strip_headers = 1'b1;
	bit        cfg_strip_html = 1'b1;
	bit        hdr_done = 1'b0;
	bit        html_msg = 1'b0;
	bit        inside_tag = 1'b0;
	int        line_len = 0;
	bit        prefix_match = 1'b1;
	int        type_pos = 0;
	bit        html_in_line = 1'b0;
	bit        blank_first = 1'b0;

	function automatic void clear_line_state();
		line_len = 0;
		prefix_match = 1'b1;
		type_pos = 0;
		html_in_line = 1'b0;
		blank_first = 1'b0;
		inside_tag = 1'b0;
	endfunction

	// one byte through the extractor; returns 1 when it gives an output item
	function automatic bit extract_step(input mbte_pkg::in_item_t it,
			output mbte_pkg::out_item_t res);
		logic [7:0] c;
		logic [7:0] lc;
		int k;
		bit keep;
		c = it.data_byte;
		lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		res = '0;
		keep = 1'b0;
		if (it.message_start) begin
			hdr_done = 1'b0;
			html_msg = 1'b0;
			clear_line_state();
		end
		if (!hdr_done) begin
			keep = !cfg_strip_headers;
			if (line_len == 0 && (c == mbte_pkg::CHAR_CR || c == mbte_pkg::CHAR_LF))
				blank_first = 1'b1;
			if (line_len < PREFIX_CHARS) begin
				if (lc != HDR_PREFIX[8*(PREFIX_CHARS-1-line_len) +: 8])
					prefix_match = 1'b0;
				line_len++;
			end
			// substring matcher for the content type, any letter case
			k = type_pos;
			while (k > 0 && lc != TYPE_PAT[8*(TYPE_CHARS-1-k) +: 8])
				k = TYPE_BORDER1[k-1] ? 1 : 0;
			if (lc == TYPE_PAT[8*(TYPE_CHARS-1-k) +: 8])
				k++;
			if (k >= TYPE_CHARS) begin
				html_in_line = 1'b1;
				k = 0;
			end
			type_pos = k;
			if (it.line_end) begin
				if (line_len >= PREFIX_CHARS && prefix_match && html_in_line)
					html_msg = 1'b1;
				if (blank_first)
					hdr_done = 1'b1;
			end
		end else if (cfg_strip_html && html_msg) begin
			if (!inside_tag) begin
				if (c == mbte_pkg::CHAR_LT) begin
					inside_tag = 1'b1;
					keep = 1'b0;
				end else begin
					keep = 1'b1;
				end
			end else begin
				if (c == mbte_pkg::CHAR_GT)
					inside_tag = 1'b0;
				keep = 1'b0;
			end
		end else begin
			keep = 1'b1;
		end
		if (it.line_end)
			clear_line_state();
		if (!keep && !it.line_end)
			return 1'b0;
		res.out_byte = keep ? c : 8'h00;
		res.byte_valid = keep;
		res.out_line_end = it.line_end;
		return 1'b1;
	endfunction

	// ---- stimulus building ----

	// the first byte after msg_fresh is set carries message_start
	task automatic put_byte(input logic [7:0] b, input bit le);
		mbte_pkg::in_item_t it;
		it.data_byte = b;
		it.line_end = le;
		it.message_start = msg_fresh;
		msg_fresh = 1'b0;
		bytes_to_send.push_back(it);
	endtask

	task automatic put_text(input string s, input bit mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
					$urandom_range(0, 1))
				c = c ^ 8'h20;
			line_buf.push_back(c);
		end
	endtask

	task automatic put_word();
		int n;
		n = $urandom_range(1, 8);
		repeat (n)
			line_buf.push_back(8'(8'h61 + $urandom_range(0, 25)
				- ($urandom_range(0, 1) * 32)));
	endtask

	task automatic close_line(input line_term_t term);
		int n;
		if (term == TERM_BARE && line_buf.size() == 0)
			term = TERM_LF;
		if (term == TERM_CRLF || term == TERM_CR)
			line_buf.push_back(mbte_pkg::CHAR_CR);
		if (term == TERM_CRLF || term == TERM_LF)
			line_buf.push_back(mbte_pkg::CHAR_LF);
		n = line_buf.size();
		for (int i = 0; i < n; i++)
			put_byte(line_buf[i], i == n - 1 && term != TERM_CUT);
		line_buf.delete();
	endtask

	function automatic line_term_t pick_term();
		case ($urandom_range(0, 3))
			0, 1: return TERM_CRLF;
			2: return TERM_LF;
			default: return TERM_BARE;
		endcase
	endfunction

	// header lines: matches, near misses and unrelated ones
	task automatic put_header();
		case ($urandom_range(0, 8))
			0: put_text("Content-Type: text/html; charset=utf-8", 1'b1);
			1: put_text("Content-Type: text/plain", 1'b1);
			2: put_text("Content-Type:text/html", 1'b1);
			3: put_text("Content-Typ: text/html", 1'b1);
			4: put_text("X-Note: text/html", 1'b1);
			5: begin
				put_text("Subject: ", 1'b1);
				put_word();
			end
			// partial pattern restarts inside the line
			6: put_text("Content-Type: x; tetext/htmtext/html", 1'b1);
			7: put_text("Content-Type: text/htm", 1'b1);
			default: put_text("To:", 1'b1);
		endcase
	endtask

	task automatic put_body_line();
		int n;
		n = $urandom_range(1, 5);
		repeat (n) begin
			case ($urandom_range(0, 8))
				0: put_text("<p>", 1'b0);
				1: put_text("<a href=x>", 1'b1);
				2: put_text("</b>", 1'b0);
				3: put_word();
				4: put_text(" ", 1'b0);
				5: put_text("<", 1'b0);
				6: put_text(">", 1'b0);
				7: line_buf.push_back(8'($urandom_range(0, 255)));
				default: line_buf.push_back(8'h00);
			endcase
		end
	endtask

	// mostly well formed messages; some lack the blank line or end mid-line
	task automatic random_message();
		int nh;
		int nb;
		int r;
		msg_fresh = 1'b1;
		nh = $urandom_range(0, 4);
		repeat (nh) begin
			put_header();
			close_line(pick_term());
		end
		r = $urandom_range(0, 9);
		if (r == 1)
			close_line(TERM_CR);
		else if (r == 2 || r == 3)
			close_line(TERM_LF);
		else if (r != 0)
			close_line(TERM_CRLF);
		nb = $urandom_range(0, 5);
		for (int i = 0; i < nb; i++) begin
			put_body_line();
			close_line((i == nb - 1 && $urandom_range(0, 7) == 0) ? TERM_CUT : pick_term());
		end
	endtask

	// raw bytes with random line and message marks
	task automatic noise_burst();
		int n;
		n = $urandom_range(20, 60);
		repeat (n) begin
			msg_fresh = ($urandom_range(0, 39) == 0);
			put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
		end
	endtask

	// ---- configuration and phase control ----

	task automatic write_reg(input logic [mbte_pkg::CfgIndexW-1:0] idx,
			input logic [mbte_pkg::CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == mbte_pkg::CFG_STRIP_HEADERS)
			cfg_strip_headers = val[0];
		else
			cfg_strip_html = val[0];
	endtask

	// all items sent and all kept text seen, then let a dropped last byte settle
	task automatic wait_idle();
		while (bytes_to_send.size() != 0 || kept_text_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ---- driver: new items and stall decisions at the falling edge ----
	always @(negedge clk) begin
		// only move on once the offered item has been taken
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= bytes_to_send[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
	end

	// ---- receiver hold-off, so the block backs up and stalls its input ----
	initial begin
		wait (pressure_go);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// ---- monitor, prediction and watchdog at the rising edge ----
	always @(posedge clk) begin
		mbte_pkg::out_item_t want;
		mbte_pkg::out_item_t pred;
		if (arst_n) begin
			quiet_cycles++;
			// results first: one taken at this edge belongs to an earlier item
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (kept_text_due.size() == 0) begin
					mismatches++;
					$display("%0t unexpected item: expected none, got %h/%b/%b", $time,
						out_item.out_byte, out_item.byte_valid, out_item.out_line_end);
				end else begin
					want = kept_text_due.pop_front();
					if (out_item.out_byte !== want.out_byte ||
							out_item.byte_valid !== want.byte_valid ||
							out_item.out_line_end !== want.out_line_end) begin
						mismatches++;
						$display("%0t mismatch: expected %h/%b/%b, got %h/%b/%b",
							$time, want.out_byte, want.byte_valid, want.out_line_end,
							out_item.out_byte, out_item.byte_valid, out_item.out_line_end);
					end
				end
			end
			if (in_valid && !in_stall) begin
				quiet_cycles = 0;
				in_taken = 1'b1;
				void'(bytes_to_send.pop_front());
				if (extract_step(in_item, pred))
					kept_text_due.push_back(pred);
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t watchdog: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("[mail_body_text_extractor_top] ERROR");
				$finish;
			end
		end
	end

	// ---- test sequence ----
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, reset settings (both strip options on)
		// zero byte that is a whole one-byte header line, with a message start
		msg_fresh = 1'b1;
		put_byte(8'h00, 1'b1);
		// partial line abandoned by a new message
		put_byte("a", 1'b0);
		msg_fresh = 1'b1;
		put_text("Content-Type:text/html", 1'b0);
		close_line(TERM_BARE);
		// blank separator, then an unclosed tag that must not leak past line end
		close_line(TERM_LF);
		put_text("<x", 1'b0);
		close_line(TERM_BARE);
		put_byte(8'hff, 1'b1);
		wait_idle();

		// random part: every setting pair, three idling patterns
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(mbte_pkg::CFG_STRIP_HEADERS, (phase % 2) == 0);
			write_reg(mbte_pkg::CFG_STRIP_HTML, ((phase / 2) % 2) == 0);
			tx_idle_pct = (phase < 2) ? 16 : (phase < 4) ? 72 : 0;
			rx_idle_pct = (phase < 2) ? 72 : (phase < 4) ? 16 : 0;
			while (bytes_to_send.size() < CHUNK_BYTES) begin
				if ($urandom_range(0, 9) == 0)
					noise_burst();
				else
					random_message();
			end
			if (phase == 4)
				pressure_go = 1'b1;
			wait_idle();
		end

		if (mismatches == 0)
			$display("[mail_body_text_extractor_top] OK");
		else
			$display("[mail_body_text_extractor_top] ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/mbte_pkg.sv
src/mail_body_text_extractor_top.sv
dv/testbench.sv
